[design/shdd_pkg.sv]
// ----------------------------------------------------------------------------
// shdd_pkg
// Shared types, constants and helpers for the scanned hysteresis debounce
// detector: register indexes and reset values, controller states, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package shdd_pkg;

    localparam int THRESH_W   = 12;   // threshold register width
    localparam int CNT_W      = 8;    // debounce and power counter width
    localparam int CFG_IDX_W  = 3;    // register index width
    localparam int CFG_DATA_W = 12;   // widest register
    localparam int CHAN_W     = 4;    // reported channel field width
    localparam int OUT_W      = 8;    // result tdata width, byte padded

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCCUPIED_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_DELAY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_DELAY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_OFF_DELAY = 3'd5;

    // Register reset values
    localparam logic [THRESH_W-1:0] LOW_THRESHOLD_RST   = 12'd1024;
    localparam logic [THRESH_W-1:0] HIGH_THRESHOLD_RST  = 12'd3072;
    localparam logic [CNT_W-1:0]    OCCUPIED_DELAY_RST  = 8'd3;
    localparam logic [CNT_W-1:0]    FREE_DELAY_RST      = 8'd3;
    localparam logic [CNT_W-1:0]    POWER_ON_DELAY_RST  = 8'd10;
    localparam logic [CNT_W-1:0]    POWER_OFF_DELAY_RST = 8'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } shdd_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic rd;       // read sample and counters of the current channel
        logic commit;   // write back the judged channel and advance
        logic flush;    // release the held report as the final one
    } shdd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_end;     // accepted beat completes a scan
        logic report;       // judged channel produces a report
        logic held_valid;   // a report waits in the hold stage
        logic out_free;     // output register can take a beat
        logic idx_last;     // current channel is the last one
    } shdd_status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : CNT_W'(v + 1'b1);
    endfunction

endpackage

[design/scanned_hysteresis_debounce_detector.sv]
// ----------------------------------------------------------------------------
// scanned_hysteresis_debounce_detector
// Multichannel ADC scan with power qualification, hysteresis thresholds and
// debounce counters; reports confirmed channel state changes.
// ----------------------------------------------------------------------------
//
//  port group   dir  payload (low bit first)                 handshake
//  s_axis       in   tdata: sample, power_absent, zero pad   tvalid/tready
//  m_axis       out  tdata: channel, occupied, zero pad;     tvalid/tready
//                    tlast: final report of the input beat
//  cfg          in   cfg_index selects register, cfg_wdata   cfg_we, no wait
//
//  Beats that do not close a scan are taken while idle. The beat that fills
//  the last slot starts the judge walk, and no beat is taken until it ends:
//  each channel gets a registered read of the sample and counter RAMs, then
//  judge and write back; a flush step follows. m_axis can stall both steps.
//  One report is held back so the final one can be marked with tlast; a
//  second report waits for the output register. No clearing pass after reset:
//  counter entries carry valid bits and the sample store is always filled
//  before it is read.
//
module scanned_hysteresis_debounce_detector #(
    parameter int CHANNELS    = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input beat
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+8)/8)*8-1:0]      s_axis_tdata,  // sample, power_absent
    // Report beat
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [shdd_pkg::OUT_W-1:0]            m_axis_tdata,  // channel, occupied
    output logic                                  m_axis_tlast,
    // Register writes
    input  logic                                  cfg_we,
    input  logic [shdd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [shdd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    import shdd_pkg::*;

    shdd_cmd_t         cmd;
    shdd_status_t      status;
    logic [CHAN_W-1:0] out_channel;
    logic              out_occupied;

    // Sequencer: owns the input handshake and steps the channel walk
    shdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: stores, counters, judge and output register
    shdd_datapath #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .sample       (s_axis_tdata[SAMPLE_BITS-1:0]),
        .power_absent (s_axis_tdata[SAMPLE_BITS]),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_channel  (out_channel),
        .out_occupied (out_occupied),
        .out_last     (m_axis_tlast)
    );

    // Pack the report beat, pad to a whole byte
    assign m_axis_tdata = OUT_W'({out_occupied, out_channel});

endmodule

[design/shdd_ram.sv]
// ----------------------------------------------------------------------------
// shdd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module shdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/shdd_ctrl.sv]
// ----------------------------------------------------------------------------
// shdd_ctrl
// Sequencer: take input beats, then walk every channel with a read and a
// judge step, and finally release the held report.
// ----------------------------------------------------------------------------
module shdd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  shdd_pkg::shdd_status_t status,
    output shdd_pkg::shdd_cmd_t    cmd
);

    import shdd_pkg::*;

    shdd_state_t state_reg;
    shdd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.scan_end)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // Stall only when a second report must pass a full output.
                if (!status.report || !status.held_valid || status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = status.idx_last ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH:
            begin
                if (!status.held_valid || status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/shdd_datapath.sv]
// ----------------------------------------------------------------------------
// shdd_datapath
// Registers, power qualification, sample and counter stores, per-channel
// hysteresis judge, report hold stage and output register.
// ----------------------------------------------------------------------------
module shdd_datapath #(
    parameter int CHANNELS    = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [shdd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [shdd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [SAMPLE_BITS-1:0]            sample,
    input  logic                              power_absent,
    input  shdd_pkg::shdd_cmd_t               cmd,
    output shdd_pkg::shdd_status_t            status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [shdd_pkg::CHAN_W-1:0]       out_channel,
    output logic                              out_occupied,
    output logic                              out_last
);

    import shdd_pkg::*;

    localparam int SLOT_W = $clog2(CHANNELS);
    localparam int CMP_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
    localparam int IDXX_W = (SLOT_W > CHAN_W) ? SLOT_W : CHAN_W;

    // Configuration
    logic [THRESH_W-1:0] low_thr_reg;
    logic [THRESH_W-1:0] high_thr_reg;
    logic [CNT_W-1:0]    occ_dly_reg;
    logic [CNT_W-1:0]    free_dly_reg;
    logic [CNT_W-1:0]    pon_dly_reg;
    logic [CNT_W-1:0]    poff_dly_reg;

    // Control state
    logic [CNT_W-1:0]    pon_cnt_reg, pon_cnt_next;
    logic [CNT_W-1:0]    poff_cnt_reg, poff_cnt_next;
    logic                power_good_reg, power_good_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [CHANNELS-1:0] cnt_valid_reg;
    logic [CHANNELS-1:0] level_high_reg;
    logic [CHANNELS-1:0] pending_reg;
    logic                held_valid_reg;
    logic                out_valid_reg, out_valid_next;

    // Payload
    logic [CHAN_W-1:0]   held_chan_reg;
    logic                held_occ_reg;
    logic [CHAN_W-1:0]   out_chan_reg;
    logic                out_occ_reg;
    logic                out_last_reg;

    // Store read data
    logic [SAMPLE_BITS-1:0] smp_rdata;
    logic [2*CNT_W-1:0]     cnt_rdata;

    // Judge
    logic [CNT_W-1:0]  occ_cur, free_cur, occ_inc, free_inc, occ_new, free_new;
    logic              lh_cur, pd_cur, lh_new, pd_new;
    logic              report, rep_occ;
    logic [CMP_W-1:0]  smp_ext, low_ext, high_ext;
    logic [IDXX_W-1:0] idx_ext;
    logic              push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= LOW_THRESHOLD_RST;
            high_thr_reg <= HIGH_THRESHOLD_RST;
            occ_dly_reg  <= OCCUPIED_DELAY_RST;
            free_dly_reg <= FREE_DELAY_RST;
            pon_dly_reg  <= POWER_ON_DELAY_RST;
            poff_dly_reg <= POWER_OFF_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOW_THRESHOLD:   low_thr_reg  <= cfg_wdata[THRESH_W-1:0];
                CFG_HIGH_THRESHOLD:  high_thr_reg <= cfg_wdata[THRESH_W-1:0];
                CFG_OCCUPIED_DELAY:  occ_dly_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_FREE_DELAY:      free_dly_reg <= cfg_wdata[CNT_W-1:0];
                CFG_POWER_ON_DELAY:  pon_dly_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_POWER_OFF_DELAY: poff_dly_reg <= cfg_wdata[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Power qualification for the beat on the input
    always_comb
    begin
        pon_cnt_next    = pon_cnt_reg;
        poff_cnt_next   = poff_cnt_reg;
        power_good_next = power_good_reg;
        if (power_absent)
        begin
            pon_cnt_next  = '0;
            poff_cnt_next = sat_inc(poff_cnt_reg);
            if (poff_cnt_next > poff_dly_reg)
            begin
                power_good_next = 1'b0;
            end
        end
        else
        begin
            poff_cnt_next = '0;
            pon_cnt_next  = sat_inc(pon_cnt_reg);
            if (pon_cnt_next > pon_dly_reg)
            begin
                power_good_next = 1'b1;
            end
        end
    end

    shdd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (CHANNELS)
    ) u_sample_ram (
        .clk   (clk),
        .we    (cmd.accept && power_good_next),
        .waddr (slot_reg),
        .wdata (sample),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (smp_rdata)
    );

    shdd_ram #(
        .WIDTH (2 * CNT_W),
        .DEPTH (CHANNELS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (idx_reg),
        .wdata ({occ_new, free_new}),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (cnt_rdata)
    );

    // Judge one channel
    always_comb
    begin
        smp_ext  = CMP_W'(smp_rdata);
        low_ext  = CMP_W'(low_thr_reg);
        high_ext = CMP_W'(high_thr_reg);
        occ_cur  = cnt_valid_reg[idx_reg] ? cnt_rdata[2*CNT_W-1:CNT_W] : '0;
        free_cur = cnt_valid_reg[idx_reg] ? cnt_rdata[CNT_W-1:0] : '0;
        lh_cur   = level_high_reg[idx_reg];
        pd_cur   = pending_reg[idx_reg];
        occ_inc  = sat_inc(occ_cur);
        free_inc = sat_inc(free_cur);
        occ_new  = occ_cur;
        free_new = free_cur;
        lh_new   = lh_cur;
        pd_new   = pd_cur;
        report   = 1'b0;
        rep_occ  = 1'b0;
        priority if (smp_ext < low_ext)
        begin
            if (lh_cur || pd_cur)
            begin
                occ_new  = occ_inc;
                free_new = '0;
                if (occ_inc > occ_dly_reg || pd_cur)
                begin
                    lh_new  = 1'b0;
                    occ_new = '0;
                    pd_new  = 1'b0;
                    report  = 1'b1;
                    rep_occ = 1'b1;
                end
            end
        end
        else if (smp_ext > high_ext)
        begin
            if (!lh_cur || pd_cur)
            begin
                occ_new  = '0;
                free_new = free_inc;
                if (free_inc > free_dly_reg || pd_cur)
                begin
                    lh_new   = 1'b1;
                    free_new = '0;
                    pd_new   = 1'b0;
                    report   = 1'b1;
                end
            end
        end
        else
        begin
            occ_new  = '0;
            free_new = '0;
        end
    end

    assign idx_ext = IDXX_W'(idx_reg);
    assign push    = held_valid_reg && ((cmd.commit && report) || cmd.flush);
    assign out_valid_next = push || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pon_cnt_reg    <= '0;
            poff_cnt_reg   <= '0;
            power_good_reg <= 1'b0;
            slot_reg       <= '0;
            idx_reg        <= '0;
            cnt_valid_reg  <= '0;
            level_high_reg <= '0;
            pending_reg    <= '1;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.accept)
            begin
                pon_cnt_reg    <= pon_cnt_next;
                poff_cnt_reg   <= poff_cnt_next;
                power_good_reg <= power_good_next;
                idx_reg        <= '0;
                if (power_good_next)
                begin
                    slot_reg <= status.scan_end ? '0 : SLOT_W'(slot_reg + 1'b1);
                end
                else
                begin
                    // Power lost: drop counters, force reports, rewind
                    slot_reg      <= '0;
                    cnt_valid_reg <= '0;
                    pending_reg   <= '1;
                end
            end
            if (cmd.commit)
            begin
                cnt_valid_reg[idx_reg]  <= 1'b1;
                level_high_reg[idx_reg] <= lh_new;
                pending_reg[idx_reg]    <= pd_new;
                idx_reg                 <= SLOT_W'(idx_reg + 1'b1);
                if (report)
                begin
                    held_valid_reg <= 1'b1;
                end
            end
            if (cmd.flush)
            begin
                held_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && report)
        begin
            held_chan_reg <= idx_ext[CHAN_W-1:0];
            held_occ_reg  <= rep_occ;
        end
        if (push)
        begin
            out_chan_reg <= held_chan_reg;
            out_occ_reg  <= held_occ_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign status.scan_end   = power_good_next && (slot_reg == SLOT_W'(CHANNELS - 1));
    assign status.report     = report;
    assign status.held_valid = held_valid_reg;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.idx_last   = (idx_reg == SLOT_W'(CHANNELS - 1));

    assign out_valid    = out_valid_reg;
    assign out_channel  = out_chan_reg;
    assign out_occupied = out_occ_reg;
    assign out_last     = out_last_reg;

endmodule
